[sv/cbfs_pkg.sv]
// shared types and constants of the colour blob follow steering block
package cbfs_pkg;

   localparam int COORD_BITS_DEF = 10;
   localparam int AREA_BITS      = 20;
   localparam int SPEED_BITS     = 12;
   localparam int TIME_BITS      = 16;
   localparam int DIM_BITS       = 10;
   localparam int CSR_IDX_BITS   = 3;
   localparam int CSR_DATA_BITS  = 16;
   localparam int HEAD_BITS      = 9;
   localparam int QUOT_BITS      = 10;

   localparam logic [AREA_BITS-1:0] AREA_FLOOR     = 20'd20;
   localparam logic [7:0]           HEAD_LIMIT     = 8'd160;
   localparam logic [7:0]           SPIN_HEADING   = 8'd128;
   localparam logic [TIME_BITS-1:0] ELAPSED_TOP    = 16'hFFFF;
   localparam logic [SPEED_BITS-1:0] SPEED_RST     = 12'd0;
   localparam logic [TIME_BITS-1:0] MAX_TIME_RST   = 16'd2000;
   localparam logic [DIM_BITS-1:0]  WIDTH_RST      = 10'd160;
   localparam logic [DIM_BITS-1:0]  HEIGHT_RST     = 10'd120;

   typedef enum logic [1:0] {
      KIND_BLOB  = 2'd0,
      KIND_FRAME = 2'd1,
      KIND_TICK  = 2'd2,
      KIND_SPARE = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      MODE_STOPPED   = 2'd0,
      MODE_FOLLOWING = 2'd1,
      MODE_ACQUIRING = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      TILT_NONE = 2'd0,
      TILT_UP   = 2'd1,
      TILT_DOWN = 2'd2,
      TILT_ZERO = 2'd3
   } tilt_type;

   typedef enum logic [1:0] {
      SIDE_CENTER = 2'd0,
      SIDE_LEFT   = 2'd1,
      SIDE_RIGHT  = 2'd2
   } side_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_SPEED      = 3'd0,
      CSR_MAX_TIME   = 3'd1,
      CSR_ACQUIRE    = 3'd2,
      CSR_MOVEMENT   = 3'd3,
      CSR_WIDTH      = 3'd4,
      CSR_HEIGHT     = 3'd5,
      CSR_SOURCE     = 3'd6,
      CSR_CAMERA     = 3'd7
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_EVAL = 4'b0010,
      ST_DIV  = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

endpackage

[sv/color_blob_follow_steering_unit.sv]
// colour blob follower: blob tracking, sighting timer and steering command sequencer
// blob report and tick beats update state in the accepting cycle, no result
// frame end: evaluation step, then ten compare-subtract steps of the shared divider
//   unit for a turn, then a done step that writes the result beat once output is free
// reports and ticks: one beat per cycle while idle, none until a frame end is done
// reset: synchronous active high; control and tracking registers reset, no result pending
module color_blob_follow_steering_unit #(
   parameter int COORD_BITS = cbfs_pkg::COORD_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // input item channel
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [1:0]                           req_kind,
   input  logic [cbfs_pkg::AREA_BITS-1:0]       req_blob_area,
   input  logic [9:0]                           req_blob_x,
   input  logic [9:0]                           req_blob_y,
   // result channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [cbfs_pkg::HEAD_BITS-1:0] rsp_heading_delta,
   output logic [cbfs_pkg::SPEED_BITS-1:0]      rsp_velocity,
   output logic [1:0]                           rsp_tilt_cmd,
   output logic                                 rsp_target_seen,
   output logic [1:0]                           rsp_move_mode,
   // register write channel
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [cbfs_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [cbfs_pkg::CSR_DATA_BITS-1:0]   csr_data
);

   // offsets 2*x - w need one bit over the wider of the doubled coordinate and the width
   localparam int XW = (COORD_BITS + 1 > cbfs_pkg::DIM_BITS) ? COORD_BITS + 1
                                                            : cbfs_pkg::DIM_BITS;
   // divider remainder width: covers 160*|dx| + w and the divisor shifted by nine
   localparam int RW = XW + 10;
   localparam int QW = cbfs_pkg::QUOT_BITS;
   localparam int DIV_STEPS = QW;
   localparam int CW = $clog2(DIV_STEPS);

   // configuration registers
   logic [cbfs_pkg::SPEED_BITS-1:0] speed_ff;
   logic [cbfs_pkg::TIME_BITS-1:0]  max_time_ff;
   logic                            acquire_ff, movement_ff, source_ff, camera_ff;
   logic [cbfs_pkg::DIM_BITS-1:0]   width_ff, height_ff;

   // tracking state
   logic [cbfs_pkg::AREA_BITS-1:0] best_area_ff, best_area_in;
   logic [COORD_BITS-1:0]          best_x_ff, best_x_in, best_y_ff, best_y_in;
   logic                           have_blob_ff, have_blob_in;
   logic                           any_blob_ff, any_blob_in;
   logic [cbfs_pkg::TIME_BITS-1:0] elapsed_ff, elapsed_in;
   cbfs_pkg::side_type             side_ff, side_in;

   // sequencer and divider
   cbfs_pkg::state_type state_ff, state_in;
   logic [RW-1:0]       rem_ff, rem_in;
   logic [RW-1:0]       dsh_ff, dsh_in;
   logic [QW-1:0]       quot_ff, quot_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic                neg_ff, neg_in;

   // result being assembled and the output register
   logic signed [cbfs_pkg::HEAD_BITS-1:0] head_ff, head_in;
   logic [cbfs_pkg::SPEED_BITS-1:0]       vel_ff, vel_in;
   cbfs_pkg::tilt_type                    tilt_ff, tilt_in;
   logic                                  seen_ff, seen_in;
   cbfs_pkg::mode_type                    mode_ff, mode_in;

   logic                                  rsp_valid_ff, rsp_valid_in;
   logic signed [cbfs_pkg::HEAD_BITS-1:0] rsp_head_ff, rsp_head_in;
   logic [cbfs_pkg::SPEED_BITS-1:0]       rsp_vel_ff, rsp_vel_in;
   logic [1:0]                            rsp_tilt_ff, rsp_tilt_in;
   logic                                  rsp_seen_ff, rsp_seen_in;
   logic [1:0]                            rsp_mode_ff, rsp_mode_in;

   // evaluation datapath
   logic [cbfs_pkg::DIM_BITS-1:0] w_eff, h_eff;
   logic signed [XW:0]            dx_s, dy_s;
   logic [XW-1:0]                 dx_mag, dy_mag;
   logic [XW+2:0]                 dx_five, dy_five;
   logic                          dead_band, tilt_hit;
   logic [XW+6:0]                 n80;
   logic                          eval_seen;
   cbfs_pkg::mode_type            eval_mode;
   logic                          step_take;
   logic [7:0]                    q_clamp;
   logic                          req_fire, out_free;

   assign req_ready = (state_ff == cbfs_pkg::ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign csr_ready = 1'b1;

   // a zero image size counts as one pixel
   assign w_eff = (width_ff == '0) ? cbfs_pkg::DIM_BITS'(1) : width_ff;
   assign h_eff = (height_ff == '0) ? cbfs_pkg::DIM_BITS'(1) : height_ff;

   assign dx_s = $signed({1'b0, XW'({best_x_ff, 1'b0})}) - $signed({1'b0, XW'(w_eff)});
   assign dy_s = $signed({1'b0, XW'({best_y_ff, 1'b0})}) - $signed({1'b0, XW'(h_eff)});
   assign dx_mag = dx_s[XW] ? XW'(-dx_s) : dx_s[XW-1:0];
   assign dy_mag = dy_s[XW] ? XW'(-dy_s) : dy_s[XW-1:0];
   assign dx_five = {1'b0, dx_mag, 2'b00} + (XW+3)'(dx_mag);
   assign dy_five = {1'b0, dy_mag, 2'b00} + (XW+3)'(dy_mag);
   // centre dead band is a tenth of the width either side
   assign dead_band = dx_five < (XW+3)'(w_eff);
   assign tilt_hit  = dy_five >= (XW+3)'({h_eff, 1'b0});
   assign n80 = {1'b0, dx_mag, 6'd0} + (XW+7)'({dx_mag, 4'd0});

   assign eval_seen = source_ff && (elapsed_ff <= max_time_ff);
   always_comb begin
      if (!source_ff) begin
         eval_mode = cbfs_pkg::MODE_STOPPED;
      end else if (eval_seen) begin
         eval_mode = cbfs_pkg::MODE_FOLLOWING;
      end else if (acquire_ff) begin
         eval_mode = cbfs_pkg::MODE_ACQUIRING;
      end else begin
         eval_mode = cbfs_pkg::MODE_STOPPED;
      end
   end

   // shared compare-subtract unit
   assign step_take = rem_ff >= dsh_ff;
   assign q_clamp = (quot_ff > QW'(cbfs_pkg::HEAD_LIMIT)) ? cbfs_pkg::HEAD_LIMIT
                                                         : quot_ff[7:0];

   always_comb begin
      best_area_in = best_area_ff;
      best_x_in    = best_x_ff;
      best_y_in    = best_y_ff;
      have_blob_in = have_blob_ff;
      any_blob_in  = any_blob_ff;
      elapsed_in   = elapsed_ff;
      side_in      = side_ff;
      state_in     = state_ff;
      rem_in       = rem_ff;
      dsh_in       = dsh_ff;
      quot_in      = quot_ff;
      cnt_in       = cnt_ff;
      neg_in       = neg_ff;
      head_in      = head_ff;
      vel_in       = vel_ff;
      tilt_in      = tilt_ff;
      seen_in      = seen_ff;
      mode_in      = mode_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_head_in  = rsp_head_ff;
      rsp_vel_in   = rsp_vel_ff;
      rsp_tilt_in  = rsp_tilt_ff;
      rsp_seen_in  = rsp_seen_ff;
      rsp_mode_in  = rsp_mode_ff;

      case (state_ff)
         cbfs_pkg::ST_IDLE: begin
            if (req_fire) begin
               case (req_kind)
                  cbfs_pkg::KIND_BLOB: begin
                     any_blob_in = 1'b1;
                     // strict compare keeps the earlier of equal areas
                     if (req_blob_area > best_area_ff) begin
                        best_area_in = req_blob_area;
                        best_x_in    = COORD_BITS'(req_blob_x);
                        best_y_in    = COORD_BITS'(req_blob_y);
                        have_blob_in = 1'b1;
                     end
                  end
                  cbfs_pkg::KIND_TICK: begin
                     if (elapsed_ff != cbfs_pkg::ELAPSED_TOP) begin
                        elapsed_in = elapsed_ff + 1'b1;
                     end
                  end
                  cbfs_pkg::KIND_FRAME: begin
                     if (source_ff && any_blob_ff) begin
                        elapsed_in = '0;
                     end
                     state_in = cbfs_pkg::ST_EVAL;
                  end
                  default: ;
               endcase
            end
         end
         cbfs_pkg::ST_EVAL: begin
            seen_in  = eval_seen;
            mode_in  = eval_mode;
            head_in  = '0;
            vel_in   = '0;
            tilt_in  = cbfs_pkg::TILT_NONE;
            state_in = cbfs_pkg::ST_DONE;
            quot_in  = '0;
            neg_in   = 1'b0;
            case (eval_mode)
               cbfs_pkg::MODE_FOLLOWING: begin
                  if (have_blob_ff) begin
                     if (camera_ff && tilt_hit) begin
                        tilt_in = dy_s[XW] ? cbfs_pkg::TILT_UP : cbfs_pkg::TILT_DOWN;
                     end
                     if (movement_ff) begin
                        vel_in = speed_ff;
                        if (dead_band) begin
                           side_in = cbfs_pkg::SIDE_CENTER;
                        end else begin
                           // round(80|dx|/w) as (160|dx| + w) / 2w
                           neg_in   = !dx_s[XW] && (dx_s != '0);
                           side_in  = neg_in ? cbfs_pkg::SIDE_LEFT : cbfs_pkg::SIDE_RIGHT;
                           rem_in   = RW'({n80, 1'b0}) + RW'(w_eff);
                           dsh_in   = RW'({w_eff, 1'b0}) << (DIV_STEPS - 1);
                           cnt_in   = CW'(DIV_STEPS - 1);
                           state_in = cbfs_pkg::ST_DIV;
                        end
                     end
                  end else if (movement_ff) begin
                     case (side_ff)
                        cbfs_pkg::SIDE_LEFT:
                           head_in = -$signed({1'b0, cbfs_pkg::HEAD_LIMIT});
                        cbfs_pkg::SIDE_RIGHT:
                           head_in = $signed({1'b0, cbfs_pkg::HEAD_LIMIT});
                        default:
                           vel_in = speed_ff;
                     endcase
                  end
               end
               cbfs_pkg::MODE_ACQUIRING: begin
                  if (camera_ff) begin
                     tilt_in = cbfs_pkg::TILT_ZERO;
                  end
                  if (movement_ff) begin
                     head_in = $signed({1'b0, cbfs_pkg::SPIN_HEADING});
                  end
               end
               default: ;
            endcase
            // frame tracking starts over
            best_area_in = cbfs_pkg::AREA_FLOOR;
            best_x_in    = '0;
            best_y_in    = '0;
            have_blob_in = 1'b0;
            any_blob_in  = 1'b0;
         end
         cbfs_pkg::ST_DIV: begin
            quot_in = {quot_ff[QW-2:0], step_take};
            if (step_take) begin
               rem_in = rem_ff - dsh_ff;
            end
            dsh_in = dsh_ff >> 1;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = cbfs_pkg::ST_DONE;
            end
         end
         cbfs_pkg::ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_head_in  = head_ff;
               if (quot_ff != '0) begin
                  rsp_head_in = neg_ff ? -$signed({1'b0, q_clamp})
                                       : $signed({1'b0, q_clamp});
               end
               rsp_vel_in  = vel_ff;
               rsp_tilt_in = tilt_ff;
               rsp_seen_in = seen_ff;
               rsp_mode_in = mode_ff;
               state_in    = cbfs_pkg::ST_IDLE;
            end
         end
         default: state_in = cbfs_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_ff     <= cbfs_pkg::SPEED_RST;
         max_time_ff  <= cbfs_pkg::MAX_TIME_RST;
         acquire_ff   <= 1'b1;
         movement_ff  <= 1'b0;
         width_ff     <= cbfs_pkg::WIDTH_RST;
         height_ff    <= cbfs_pkg::HEIGHT_RST;
         source_ff    <= 1'b1;
         camera_ff    <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            cbfs_pkg::CSR_SPEED:    speed_ff    <= csr_data[cbfs_pkg::SPEED_BITS-1:0];
            cbfs_pkg::CSR_MAX_TIME: max_time_ff <= csr_data[cbfs_pkg::TIME_BITS-1:0];
            cbfs_pkg::CSR_ACQUIRE:  acquire_ff  <= csr_data[0];
            cbfs_pkg::CSR_MOVEMENT: movement_ff <= csr_data[0];
            cbfs_pkg::CSR_WIDTH:    width_ff    <= csr_data[cbfs_pkg::DIM_BITS-1:0];
            cbfs_pkg::CSR_HEIGHT:   height_ff   <= csr_data[cbfs_pkg::DIM_BITS-1:0];
            cbfs_pkg::CSR_SOURCE:   source_ff   <= csr_data[0];
            cbfs_pkg::CSR_CAMERA:   camera_ff   <= csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_area_ff <= cbfs_pkg::AREA_FLOOR;
         best_x_ff    <= '0;
         best_y_ff    <= '0;
         have_blob_ff <= 1'b0;
         any_blob_ff  <= 1'b0;
         elapsed_ff   <= '0;
         side_ff      <= cbfs_pkg::SIDE_CENTER;
         state_ff     <= cbfs_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         best_area_ff <= best_area_in;
         best_x_ff    <= best_x_in;
         best_y_ff    <= best_y_in;
         have_blob_ff <= have_blob_in;
         any_blob_ff  <= any_blob_in;
         elapsed_ff   <= elapsed_in;
         side_ff      <= side_in;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath, no reset needed
   always_ff @(posedge clock) begin
      rem_ff      <= rem_in;
      dsh_ff      <= dsh_in;
      quot_ff     <= quot_in;
      cnt_ff      <= cnt_in;
      neg_ff      <= neg_in;
      head_ff     <= head_in;
      vel_ff      <= vel_in;
      tilt_ff     <= tilt_in;
      seen_ff     <= seen_in;
      mode_ff     <= mode_in;
      rsp_head_ff <= rsp_head_in;
      rsp_vel_ff  <= rsp_vel_in;
      rsp_tilt_ff <= rsp_tilt_in;
      rsp_seen_ff <= rsp_seen_in;
      rsp_mode_ff <= rsp_mode_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_heading_delta = rsp_head_ff;
   assign rsp_velocity      = rsp_vel_ff;
   assign rsp_tilt_cmd      = rsp_tilt_ff;
   assign rsp_target_seen   = rsp_seen_ff;
   assign rsp_move_mode     = rsp_mode_ff;

`ifndef NO_ASSERTIONS
   a_frame_to_eval: assert property (@(posedge clock) disable iff (reset)
      req_fire && (req_kind == cbfs_pkg::KIND_FRAME) |=> state_ff == cbfs_pkg::ST_EVAL)
      else $error("frame end beat did not start evaluation");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == cbfs_pkg::ST_DONE))
      else $error("result beat raised outside the done step");

   a_head_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_head_ff <= 9'sd160) && (rsp_head_ff >= -9'sd160))
      else $error("heading outside the clamp");

   a_follow_seen: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_mode_ff == cbfs_pkg::MODE_FOLLOWING) == rsp_seen_ff)
      else $error("follow mode and sighting disagree");

   a_div_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == cbfs_pkg::ST_DIV |-> cnt_ff <= CW'(DIV_STEPS - 1))
      else $error("divider step count out of range");
`endif

endmodule
